/* hdl/assert_macros.svh */
// Assertion macros for the RTL of the atan2 block.
// No dependencies; included by vector_angle_atan2, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/vaa_pkg.sv */
// Package for the atan2 block: widths, CORDIC angle table, rounding helper.
// No dependencies; imported by vaa_stage and vector_angle_atan2.
`default_nettype none

package vaa_pkg;

    localparam int IN_WIDTH        = 16;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int STAGES          = 16;

    localparam int GUARD     = 24;
    localparam int Q_FRAC    = 30;
    localparam int OUT_WIDTH = ANGLE_FRAC_BITS + 3;
    // Data path: input, guard bits, plus headroom for CORDIC gain and the pi turn.
    localparam int DW        = IN_WIDTH + GUARD + 3;
    // Angle accumulator in Q2.30 with room for the pi offset on top.
    localparam int ZW        = Q_FRAC + 5;
    localparam int SH        = Q_FRAC - ANGLE_FRAC_BITS;
    localparam int IDX_W     = $clog2(STAGES);
    localparam int RW        = ZW - SH;

    localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
    localparam logic signed [ZW-1:0] ROUND_BIAS  = ZW'(64'sd1 <<< (SH - 1));

    typedef struct packed {
        logic signed [DW-1:0]        x;
        logic signed [DW-1:0]        y;
        logic signed [ZW-1:0]        z;
        logic                        xneg;
        logic                        yneg;
        logic                        special;
        logic signed [OUT_WIDTH-1:0] special_val;
    } t_cordic;

    // Round half up from Q2.30 to the output format.
    function automatic logic signed [OUT_WIDTH-1:0] round_q(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] r;
        r = z + ROUND_BIAS;
        return OUT_WIDTH'(r >>> SH);
    endfunction

    localparam logic signed [OUT_WIDTH-1:0] PI_OUT      = round_q(PI_Q30);
    localparam logic signed [OUT_WIDTH-1:0] HALF_PI_OUT = round_q(HALF_PI_Q30);

    // atan(2^-i) in Q2.30.
    function automatic logic signed [ZW-1:0] elem_angle(input logic [4:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            5'd0:    a = ZW'(64'sd843314857);
            5'd1:    a = ZW'(64'sd497837829);
            5'd2:    a = ZW'(64'sd263043837);
            5'd3:    a = ZW'(64'sd133525159);
            5'd4:    a = ZW'(64'sd67021687);
            5'd5:    a = ZW'(64'sd33543516);
            5'd6:    a = ZW'(64'sd16775851);
            5'd7:    a = ZW'(64'sd8388437);
            5'd8:    a = ZW'(64'sd4194283);
            5'd9:    a = ZW'(64'sd2097149);
            5'd10:   a = ZW'(64'sd1048576);
            5'd11:   a = ZW'(64'sd524288);
            5'd12:   a = ZW'(64'sd262144);
            5'd13:   a = ZW'(64'sd131072);
            5'd14:   a = ZW'(64'sd65536);
            5'd15:   a = ZW'(64'sd32768);
            5'd16:   a = ZW'(64'sd16384);
            5'd17:   a = ZW'(64'sd8192);
            5'd18:   a = ZW'(64'sd4096);
            5'd19:   a = ZW'(64'sd2048);
            5'd20:   a = ZW'(64'sd1024);
            5'd21:   a = ZW'(64'sd512);
            5'd22:   a = ZW'(64'sd256);
            5'd23:   a = ZW'(64'sd128);
            5'd24:   a = ZW'(64'sd64);
            5'd25:   a = ZW'(64'sd32);
            5'd26:   a = ZW'(64'sd16);
            5'd27:   a = ZW'(64'sd8);
            5'd28:   a = ZW'(64'sd4);
            5'd29:   a = ZW'(64'sd2);
            5'd30:   a = ZW'(64'sd1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* hdl/vaa_stage.sv */
// One registered CORDIC vectoring micro-rotation with its own valid/ready slot.
// Depends on vaa_pkg for the data record, widths and the angle table.
`default_nettype none

module vaa_stage import vaa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_up_vld,
    input  t_cordic          i_up_data,
    output logic             o_up_ready,
    output logic             o_dn_vld,
    output t_cordic          o_dn_data,
    input  logic             i_dn_ready
);

    logic    r_vld;
    t_cordic r_data;
    t_cordic n_data;

    logic signed [DW-1:0] sx;
    logic signed [DW-1:0] sy;
    logic signed [ZW-1:0] a;

    assign o_up_ready = !r_vld || i_dn_ready;
    assign o_dn_vld   = r_vld;
    assign o_dn_data  = r_data;

    always_comb begin
        sx     = i_up_data.x >>> i_idx;
        sy     = i_up_data.y >>> i_idx;
        a      = elem_angle(5'(i_idx));
        n_data = i_up_data;
        // Turn towards the x axis: the sign of y picks the direction.
        if (!i_up_data.y[DW-1]) begin
            n_data.x = i_up_data.x + sy;
            n_data.y = i_up_data.y - sx;
            n_data.z = i_up_data.z + a;
        end else begin
            n_data.x = i_up_data.x - sy;
            n_data.y = i_up_data.y + sx;
            n_data.z = i_up_data.z - a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_up_ready) begin
            r_vld <= i_up_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_vld) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/vector_angle_atan2.sv */
// atan2 block: four-quadrant angle of a signed vector, pipelined CORDIC.
// Depends on vaa_pkg, vaa_stage and assert_macros.svh.
//
// Input channel: i_valid, o_stall, i_coord_x, i_coord_y (signed integers).
// Output channel: o_valid, i_stall, o_angle (signed Q3.12 radians, -pi..+pi).
// A transaction moves at a rising edge where valid is high and stall is low.
//
// The pipeline has one input stage that sign-extends, turns left-half vectors
// by pi and flags the axis cases, one register per CORDIC micro-rotation, and
// one output stage that undoes the pi turn, rounds and saturates.
// Throughput is one transaction per cycle while the receiver does not stall;
// each micro-rotation stage holds one item.
//
// Every stage has its own valid bit and is free to load whenever it is empty
// or its successor moves, so bubbles close up while the receiver stalls. A
// stalled output holds its value; the input stalls only once every stage is
// full. Reset clears all valid bits and the block comes out empty and ready.
`default_nettype none

module vector_angle_atan2 import vaa_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [IN_WIDTH-1:0]  i_coord_x,
    input  logic signed [IN_WIDTH-1:0]  i_coord_y,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [OUT_WIDTH-1:0] o_angle
);

`include "assert_macros.svh"

    logic    w_vld [0:STAGES];
    t_cordic w_dat [0:STAGES];
    logic    w_rdy [0:STAGES+1];

    // Input stage.
    logic    r_pre_vld;
    t_cordic r_pre;
    t_cordic n_pre;

    logic signed [DW-1:0] x_ext;
    logic signed [DW-1:0] y_ext;
    logic                 x_zero;
    logic                 y_zero;

    always_comb begin
        x_ext  = DW'(i_coord_x) <<< GUARD;
        y_ext  = DW'(i_coord_y) <<< GUARD;
        x_zero = (i_coord_x == '0);
        y_zero = (i_coord_y == '0);

        n_pre.xneg        = i_coord_x[IN_WIDTH-1];
        n_pre.yneg        = i_coord_y[IN_WIDTH-1];
        n_pre.z           = '0;
        n_pre.special     = x_zero || y_zero;
        n_pre.special_val = '0;
        n_pre.x           = n_pre.xneg ? -x_ext : x_ext;
        n_pre.y           = n_pre.xneg ? -y_ext : y_ext;

        if (x_zero && !y_zero) begin
            n_pre.special_val = n_pre.yneg ? -HALF_PI_OUT : HALF_PI_OUT;
        end else if (y_zero && !x_zero && n_pre.xneg) begin
            n_pre.special_val = PI_OUT;
        end
    end

    assign w_rdy[0] = !r_pre_vld || w_rdy[1];
    assign o_stall  = !w_rdy[0];
    assign w_vld[0] = r_pre_vld;
    assign w_dat[0] = r_pre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_vld <= 1'b0;
        end else if (w_rdy[0]) begin
            r_pre_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_pre <= n_pre;
        end
    end

    // CORDIC micro-rotations.
    for (genvar k = 1; k <= STAGES; k++) begin : g_stage
        vaa_stage u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (IDX_W'(k - 1)),
            .i_up_vld   (w_vld[k-1]),
            .i_up_data  (w_dat[k-1]),
            .o_up_ready (w_rdy[k]),
            .o_dn_vld   (w_vld[k]),
            .o_dn_data  (w_dat[k]),
            .i_dn_ready (w_rdy[k+1])
        );
    end

    // Output stage: undo the pi turn, round half up, saturate to +-pi; axis cases take their flagged value.
    logic                        r_out_vld;
    logic signed [OUT_WIDTH-1:0] r_angle;
    logic signed [OUT_WIDTH-1:0] n_angle;

    logic signed [ZW-1:0] z_fix;
    logic signed [ZW-1:0] z_rnd;
    logic signed [RW-1:0] res;
    t_cordic              last;

    always_comb begin
        last  = w_dat[STAGES];
        z_fix = last.z;
        if (last.xneg) begin
            z_fix = last.yneg ? (last.z - PI_Q30) : (last.z + PI_Q30);
        end
        z_rnd = z_fix + ROUND_BIAS;
        res   = RW'(z_rnd >>> SH);
        if (last.special) begin
            n_angle = last.special_val;
        end else if (res > RW'(PI_OUT)) begin
            n_angle = PI_OUT;
        end else if (res < -RW'(PI_OUT)) begin
            n_angle = -PI_OUT;
        end else begin
            n_angle = OUT_WIDTH'(res);
        end
    end

    assign w_rdy[STAGES+1] = !r_out_vld || !i_stall;
    assign o_valid         = r_out_vld;
    assign o_angle         = r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_rdy[STAGES+1]) begin
            r_out_vld <= w_vld[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[STAGES+1] && w_vld[STAGES]) begin
            r_angle <= n_angle;
        end
    end

    // Checks.
    `ASSERT_IMPLY(a_angle_range, i_clk, i_rst_n, o_valid, (o_angle >= -PI_OUT) && (o_angle <= PI_OUT))
    `ASSERT_IMPLY(a_chain_ready, i_clk, i_rst_n, !i_stall, !o_stall)
    `ASSERT_NEXT(a_zero_special, i_clk, i_rst_n, i_valid && !o_stall && (i_coord_x == '0) && (i_coord_y == '0), r_pre_vld && r_pre.special && (r_pre.special_val == '0))

endmodule

`default_nettype wire
